// ===== rtl/stab_pkg.sv =====
// Shared types and codes for the sorted key/value table.
// No dependencies; imported by the top level.
package stab_pkg;

  localparam int IndexW  = 7;
  localparam int StatusW = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DECIDE,
    S_SHIFT,
    S_FINISH,
    S_RESP
  } state_e;

endpackage

// ===== rtl/stab_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stab_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/sorted_table_insert_find_remove_top.sv =====
// Sorted key/value table with binary search, insert, find and remove.
// Depends on stab_pkg and stab_ram (one RAM holding {key, value} per entry).
//
// Request channel: in_valid_i / in_stall_o carry operation_i, key_i, value_i.
// Result channel: out_valid_o / out_stall_i carry index_o, added_o, status_o.
// A beat moves on a rising edge with valid high and stall low. One result
// beat per request beat, in order.
// One request is worked on at a time. Each binary-search probe is a RAM
// read (S_PROBE), then a compare (S_CMP); at most clog2(count+1) probes.
// An insert of a new key or a remove of a present key then shifts the n
// entries from the position up (insert) or above it (remove) through the
// RAM port, one entry per cycle. The next request is taken in the cycle
// after the result is loaded.
// The result sits in an output register; the next request is taken while it
// waits. A stalled receiver holds the result and, once the next request is
// done, holds that request's completion as well.
// Reset empties the table (count to zero) at once; no clearing pass.
module sorted_table_insert_find_remove_top
  import stab_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [31:0]        key_i,
  input  logic [31:0]        value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IndexW-1:0]  index_o,
  output logic               added_o,
  output logic [StatusW-1:0] status_o
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);
  localparam int DataW = KEY_BITS + VALUE_BITS;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  state_e state_q, state_d;

  op_e                  op_q, op_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CntW-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                 hit_q, hit_d;
  logic [CntW-1:0]      pos_q, pos_d;
  logic [CntW-1:0]      ptr_q, ptr_d, last_q, last_d;
  logic                 more_q, more_d, pend_q, pend_d;
  logic [AddrW-1:0]     paddr_q, paddr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 res_added_q, res_added_d;
  status_e              res_status_q, res_status_d;
  logic [CntW-1:0]      res_index_q, res_index_d;

  logic                 out_valid_q, out_valid_d;
  logic [IndexW-1:0]    index_q, index_d;
  logic                 added_q, added_d;
  status_e              status_q, status_d;

  logic                 we;
  logic [AddrW-1:0]     waddr, raddr;
  logic [DataW-1:0]     wdata, rdata;

  logic [KEY_BITS+31:0]   key_ext;
  logic [VALUE_BITS+31:0] val_ext;
  logic [CntW:0]          mid_sum;
  logic [CntW-1:0]        mid_w;
  logic [KEY_BITS-1:0]    probe_key;
  logic [CntW+IndexW-1:0] res_index_ext;
  logic                   out_free;

  assign key_ext   = (KEY_BITS + 32)'(key_i);
  assign val_ext   = (VALUE_BITS + 32)'(value_i);
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w     = mid_sum[CntW:1];
  assign probe_key = rdata[DataW-1:VALUE_BITS];
  assign res_index_ext = (CntW + IndexW)'(res_index_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  stab_ram #(
    .WIDTH(DataW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PROBE;
      end
      S_PROBE: begin
        state_d = (lo_q < hi_q) ? S_CMP : S_DECIDE;
      end
      S_CMP: begin
        state_d = (key_q == probe_key) ? S_DECIDE : S_PROBE;
      end
      S_DECIDE: begin
        if (op_q == OP_INSERT) begin
          if (hit_q || count_q == CapCnt) state_d = S_RESP;
          else if (pos_q != count_q)      state_d = S_SHIFT;
          else                            state_d = S_FINISH;
        end else if (op_q == OP_REMOVE && hit_q) begin
          state_d = (pos_q + 1'b1 < count_q) ? S_SHIFT : S_FINISH;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (!more_q) state_d = S_FINISH;
      end
      S_FINISH: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    hit_d        = hit_q;
    pos_d        = pos_q;
    ptr_d        = ptr_q;
    last_d       = last_q;
    more_d       = more_q;
    pend_d       = pend_q;
    paddr_d      = paddr_q;
    count_d      = count_q;
    res_added_d  = res_added_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    out_valid_d  = out_valid_q;
    index_d      = index_q;
    added_d      = added_q;
    status_d     = status_q;
    we           = 1'b0;
    waddr        = pos_q[AddrW-1:0];
    wdata        = {key_q, val_q};
    raddr        = mid_w[AddrW-1:0];

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = op_e'(operation_i);
          key_d = key_ext[KEY_BITS-1:0];
          val_d = val_ext[VALUE_BITS-1:0];
          lo_d  = '0;
          hi_d  = count_q;
          hit_d = 1'b0;
        end
      end
      S_PROBE: begin
        mid_d = mid_w;
        if (lo_q >= hi_q) pos_d = lo_q;
      end
      S_CMP: begin
        if (key_q == probe_key) begin
          hit_d = 1'b1;
          pos_d = mid_q;
        end else if (key_q < probe_key) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + 1'b1;
        end
      end
      S_DECIDE: begin
        res_added_d  = 1'b0;
        res_status_d = ST_OK;
        res_index_d  = pos_q;
        pend_d       = 1'b0;
        if (op_q == OP_INSERT) begin
          if (hit_q) begin
            we = 1'b1;
          end else if (count_q == CapCnt) begin
            res_status_d = ST_FULL;
          end else begin
            res_added_d = 1'b1;
            ptr_d       = count_q - 1'b1;
            last_d      = pos_q;
            more_d      = 1'b1;
          end
        end else if (op_q == OP_REMOVE && hit_q) begin
          ptr_d  = pos_q + 1'b1;
          last_d = count_q - 1'b1;
          more_d = 1'b1;
        end else if (!hit_q) begin
          res_status_d = ST_MISSING;
          res_index_d  = '0;
        end
      end
      S_SHIFT: begin
        raddr = ptr_q[AddrW-1:0];
        we    = pend_q;
        waddr = paddr_q;
        wdata = rdata;
        pend_d = more_q;
        if (op_q == OP_INSERT) begin
          paddr_d = AddrW'(ptr_q + 1'b1);
          ptr_d   = ptr_q - 1'b1;
        end else begin
          paddr_d = AddrW'(ptr_q - 1'b1);
          ptr_d   = ptr_q + 1'b1;
        end
        more_d = more_q && (ptr_q != last_q);
      end
      S_FINISH: begin
        if (op_q == OP_INSERT) begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          index_d     = res_index_ext[IndexW-1:0];
          added_d     = res_added_q;
          status_d    = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    hit_q        <= hit_d;
    pos_q        <= pos_d;
    ptr_q        <= ptr_d;
    last_q       <= last_d;
    paddr_q      <= paddr_d;
    res_added_q  <= res_added_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    index_q      <= index_d;
    added_q      <= added_d;
    status_q     <= status_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign index_o     = index_q;
  assign added_o     = added_q;
  assign status_o    = status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  a_count_only_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FINISH) |=> (count_q == $past(count_q)))
    else $error("entry count changed outside finish");

  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_CMP || state_q == S_IDLE) |-> !we)
    else $error("table write during search");

  a_shift_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && we) |-> (CntW'(waddr) <= count_q))
    else $error("shift write beyond entries in use");

endmodule
